@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while in reset.
`define FIR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define FIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `FIR_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ rtl/core/fir16_pkg.sv @@
package fir16_pkg;

    localparam int TAP_COUNT_DEF = 16;
    localparam int SAMPLE_W      = 16;
    localparam int COEFF_W       = 16;
    localparam int PROD_W        = SAMPLE_W + COEFF_W;
    localparam int OUT_W         = 16;
    localparam int FRAC_BITS     = 15;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 8;

    localparam logic signed [OUT_W-1:0] SAT_HIGH = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] SAT_LOW  = 16'sh8000;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

@@ rtl/core/fir16_cell.sv @@
module fir16_cell
    import fir16_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [COEFF_W-1:0]  i_coeff,
    output logic signed [SAMPLE_W-1:0] o_hist,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic signed [SAMPLE_W-1:0] r_hist;
    logic signed [PROD_W-1:0]   r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (i_ctl.clear) begin
            r_hist <= '0;
        end else if (i_ctl.shift) begin
            r_hist <= i_sample;
        end
    end

    // product is taken on the sample entering this tap, i.e. the new history
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_prod <= i_coeff * i_sample;
        end
    end

    assign o_hist = r_hist;
    assign o_prod = r_prod;

endmodule

@@ rtl/core/fir16_tree.sv @@
module fir16_tree
    import fir16_pkg::*;
#(
    parameter  int TAP_COUNT = TAP_COUNT_DEF,
    localparam int LEVELS    = $clog2(TAP_COUNT),
    localparam int SUM_W     = PROD_W + LEVELS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    output logic                     o_rdy,
    input  logic signed [PROD_W-1:0] i_prod [TAP_COUNT],
    output logic                     o_vld,
    input  logic                     i_rdy,
    output logic signed [SUM_W-1:0]  o_sum
);

    // heap numbering: node n has children 2n and 2n+1, leaves are the products
    logic signed [SUM_W-1:0] w_val  [1:2*TAP_COUNT-1];
    logic signed [SUM_W-1:0] r_node [1:TAP_COUNT-1];
    logic [LEVELS-1:0]       r_vld;
    logic [LEVELS-1:0]       w_rdy;
    logic [LEVELS-1:0]       w_in_vld;

    genvar gi, gd, gj;

    for (gi = 0; gi < TAP_COUNT; gi++) begin : g_leaf
        assign w_val[TAP_COUNT+gi] = SUM_W'(i_prod[gi]);
    end

    for (gd = 0; gd < LEVELS; gd++) begin : g_lvl
        if (gd == LEVELS - 1) begin : g_first
            assign w_in_vld[gd] = i_vld;
        end else begin : g_mid
            assign w_in_vld[gd] = r_vld[gd+1];
        end

        if (gd == 0) begin : g_root
            assign w_rdy[gd] = !r_vld[gd] || i_rdy;
        end else begin : g_inner
            assign w_rdy[gd] = !r_vld[gd] || w_rdy[gd-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gd] <= 1'b0;
            end else if (w_rdy[gd]) begin
                r_vld[gd] <= w_in_vld[gd];
            end
        end

        for (gj = 0; gj < (1 << gd); gj++) begin : g_node
            localparam int N = (1 << gd) + gj;

            assign w_val[N] = r_node[N];

            always_ff @(posedge i_clk) begin
                if (w_rdy[gd] && w_in_vld[gd]) begin
                    r_node[N] <= w_val[2*N] + w_val[2*N+1];
                end
            end
        end
    end

    assign o_rdy = w_rdy[LEVELS-1];
    assign o_vld = r_vld[0];
    assign o_sum = r_node[1];

endmodule

@@ rtl/core/fir16_q15_saturating_unit.sv @@
// Pipeline: product register, four adder-tree levels, saturating output register.
// Throughput: one word per cycle until a stalled output fills the pipe;
//   each tap cell has its own multiplier.
// A clear word zeroes the history and yields no result.
// Reset (synchronous, active low) zeroes the history, coefficients and all valids.
module fir16_q15_saturating_unit
    import fir16_pkg::*;
#(
    parameter int TAP_COUNT = TAP_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_W-1:0]    o_filtered_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int TAPS_PER_WORD = CFG_W / COEFF_W;
    localparam int CFG_WORDS     = TAP_COUNT / TAPS_PER_WORD;
    localparam int SUM_W         = PROD_W + $clog2(TAP_COUNT);
    localparam int TOP_LSB       = FRAC_BITS + OUT_W - 1;

    logic [CFG_W-1:0]           r_coeff [CFG_WORDS];
    t_cell_ctl                  w_ctl;
    logic                       w_acc;
    logic signed [SAMPLE_W-1:0] w_hist [TAP_COUNT];
    logic signed [PROD_W-1:0]   w_prod [TAP_COUNT];
    logic                       r_p_vld;
    logic                       w_tree_rdy;
    logic                       w_tree_vld;
    logic signed [SUM_W-1:0]    w_sum;
    logic                       w_out_rdy;
    logic                       w_in_range;
    logic signed [OUT_W-1:0]    n_out;
    logic                       r_out_vld;
    logic signed [OUT_W-1:0]    r_out;

    genvar gw, gk;

    assign o_cfg_ready = 1'b1;

    // writes beyond the last word match no entry and are dropped
    for (gw = 0; gw < CFG_WORDS; gw++) begin : g_cfg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coeff[gw] <= '0;
            end else if (i_cfg_valid && i_cfg_index == CFG_IDX_W'(gw)) begin
                r_coeff[gw] <= i_cfg_data;
            end
        end
    end

    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_ctl.shift = w_acc && (i_cmd == CMD_FILTER);
    assign w_ctl.clear = w_acc && (i_cmd == CMD_CLEAR);

    for (gk = 0; gk < TAP_COUNT; gk++) begin : g_tap
        logic signed [SAMPLE_W-1:0] w_feed;

        if (gk == 0) begin : g_head
            assign w_feed = i_sample_in;
        end else begin : g_link
            assign w_feed = w_hist[gk-1];
        end

        fir16_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sample (w_feed),
            .i_coeff  (r_coeff[gk/TAPS_PER_WORD][(gk%TAPS_PER_WORD)*COEFF_W +: COEFF_W]),
            .o_hist   (w_hist[gk]),
            .o_prod   (w_prod[gk])
        );
    end

    // products held in the cells are a pipeline stage of their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_ctl.shift) begin
            r_p_vld <= 1'b1;
        end else if (w_tree_rdy) begin
            r_p_vld <= 1'b0;
        end
    end

    assign o_in_stall = r_p_vld && !w_tree_rdy;

    fir16_tree #(
        .TAP_COUNT (TAP_COUNT)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p_vld),
        .o_rdy   (w_tree_rdy),
        .i_prod  (w_prod),
        .o_vld   (w_tree_vld),
        .i_rdy   (w_out_rdy),
        .o_sum   (w_sum)
    );

    // shifted sum fits 16 bits iff the bits above it all equal the sign
    assign w_in_range = (&w_sum[SUM_W-1:TOP_LSB]) || !(|w_sum[SUM_W-1:TOP_LSB]);

    always_comb begin
        if (w_in_range) begin
            n_out = w_sum[TOP_LSB:FRAC_BITS];
        end else if (w_sum[SUM_W-1]) begin
            n_out = SAT_LOW;
        end else begin
            n_out = SAT_HIGH;
        end
    end

    assign w_out_rdy = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_rdy) begin
            r_out_vld <= w_tree_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_tree_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_filtered_out = r_out;

endmodule

@@ rtl/core/fir16_checker.sv @@
`include "assert_macros.svh"

module fir16_checker
    import fir16_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_cmd,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [OUT_W-1:0]    o_filtered_out
);

    logic w_filt_acc;

    assign w_filt_acc = i_in_valid && !o_in_stall && (i_cmd == CMD_FILTER);

    `FIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result word dropped while stalled")
    `FIR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_filtered_out), "stalled result word changed")
    // input back-pressure only arises once the pipe is full up to a stalled output
    `FIR_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled with room in the pipe")
    // free-flowing output: an accepted filter word comes out through the product, tree and output registers
    `FIR_ASSERT(a_latency, i_clk, i_rst_n, w_filt_acc ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall ##1 !i_out_stall |=> o_out_valid, "result word late")

endmodule

bind fir16_q15_saturating_unit fir16_checker u_fir16_checker (.*);

@@ verif/tb_fir16_q15_saturating_unit.sv @@
`timescale 1ns / 1ps

module tb_fir16_q15_saturating_unit;
    import fir16_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_PRINTS   = 200;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_0 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_2 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_3 = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 8'd255;

    typedef enum int {COEF_FULL, COEF_SMALL, COEF_LANE_EXTREME} t_coef_style;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       o_in_stall;
    logic                       i_cmd          = CMD_FILTER;
    logic signed [SAMPLE_W-1:0] i_sample_in    = '0;
    logic                       o_out_valid;
    logic                       i_out_stall    = 1'b0;
    logic signed [OUT_W-1:0]    o_filtered_out;
    logic                       i_cfg_valid    = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [CFG_W-1:0]           i_cfg_data     = '0;

    // filter state as the block should hold it
    logic signed [SAMPLE_W-1:0] model_hist [TAP_COUNT_DEF];
    logic [CFG_W-1:0]           model_coeff [4];
    logic signed [OUT_W-1:0]    pending_filtered [$];

    int error_count   = 0;
    bit tx_idle_en    = 1'b0;
    bit rx_idle_en    = 1'b0;
    int rx_hold_len   = 0;
    int rx_hold_token = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;

    fir16_q15_saturating_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_sample_in    (i_sample_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_filtered_out (o_filtered_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("fir16_q15_saturating_unit verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // exact sum of products, floor shift, then clamp to 16 bits
    function automatic logic signed [OUT_W-1:0] fir_sum_saturate();
        longint acc;
        longint shifted;
        logic signed [COEFF_W-1:0] c;
        acc = 0;
        for (int t = 0; t < TAP_COUNT_DEF; t++) begin
            c = $signed(model_coeff[t / 4][(t % 4) * 16 +: 16]);
            acc += longint'(c) * longint'(model_hist[t]);
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > longint'(SAT_HIGH)) return SAT_HIGH;
        if (shifted < longint'(SAT_LOW)) return SAT_LOW;
        return OUT_W'(shifted);
    endfunction

    task automatic track_accepted(input logic cmd, input logic signed [SAMPLE_W-1:0] sample);
        if (cmd == CMD_CLEAR) begin
            for (int t = 0; t < TAP_COUNT_DEF; t++) model_hist[t] = '0;
        end else begin
            for (int t = TAP_COUNT_DEF - 1; t > 0; t--) model_hist[t] = model_hist[t - 1];
            model_hist[0] = sample;
            pending_filtered.push_back(fir_sum_saturate());
        end
    endtask

    // random gaps before roughly one word in twelve: about a fifth idle
    task automatic send_word(input logic cmd, input logic signed [SAMPLE_W-1:0] sample);
        if (tx_idle_en && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_sample_in <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_accepted(cmd, sample);
    endtask

    // leaves valid high so back-to-back writes need no gap; callers lower it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= REG_COEFF_3) model_coeff[idx[1:0]] = data;
    endtask

    task automatic load_coeffs(input logic [CFG_W-1:0] w0, input logic [CFG_W-1:0] w1,
                               input logic [CFG_W-1:0] w2, input logic [CFG_W-1:0] w3);
        write_reg(REG_COEFF_0, w0);
        write_reg(REG_COEFF_1, w1);
        write_reg(REG_COEFF_2, w2);
        write_reg(REG_COEFF_3, w3);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_filtered.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pack4(input logic [15:0] c0, input logic [15:0] c1,
                                               input logic [15:0] c2, input logic [15:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [CFG_W-1:0] rand_coeff_word(input t_coef_style style);
        logic [CFG_W-1:0] w;
        logic [15:0] lane;
        w = '0;
        for (int k = 0; k < 4; k++) begin
            case (style)
                COEF_FULL:  lane = 16'($urandom);
                COEF_SMALL: lane = 16'($urandom_range(0, 8191)) - 16'd4096;
                default: begin
                    case ($urandom_range(3))
                        0:       lane = 16'h7FFF;
                        1:       lane = 16'h8000;
                        2:       lane = 16'h0000;
                        default: lane = 16'hFFFF;
                    endcase
                end
            endcase
            w[k * 16 +: 16] = lane;
        end
        return w;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        return SAMPLE_W'($urandom);
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold_token != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_token;
            rx_hold_left <= rx_hold_len;
            i_out_stall  <= 1'b1;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_stall  <= 1'b1;
        end else if (rx_idle_en) begin
            i_out_stall <= ($urandom_range(99) < 20);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_filtered.size() == 0) begin
                report_mismatch($sformatf("unexpected word, filtered_out=%0d", o_filtered_out));
            end else begin
                want = pending_filtered.pop_front();
                if (o_filtered_out !== want)
                    report_mismatch($sformatf("filtered_out=%0d, wanted %0d",
                                              o_filtered_out, want));
            end
        end
    end

    // coefficients are zero out of reset, so every word filters to zero
    task automatic test_reset_state();
        send_word(CMD_FILTER, 16'sh7FFF);
        send_word(CMD_FILTER, 16'sh8000);
        i_in_valid <= 1'b0;
    endtask

    task automatic test_unity_tap();
        wait_idle();
        load_coeffs(pack4(16'h7FFF, 16'h0, 16'h0, 16'h0), '0, '0, '0);
        send_word(CMD_FILTER, 16'sh7FFF);
        send_word(CMD_FILTER, 16'sh8000);
        send_word(CMD_FILTER, -16'sd1);     // floors to -1, not 0
        send_word(CMD_FILTER, 16'sd1);
        send_word(CMD_FILTER, 16'sd0);
        i_in_valid <= 1'b0;
    endtask

    task automatic test_saturation();
        wait_idle();
        load_coeffs({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        repeat (3) send_word(CMD_FILTER, 16'sh7FFF);
        repeat (4) send_word(CMD_FILTER, 16'sh8000);
        i_in_valid <= 1'b0;
        wait_idle();
        // -1.0 * -32768 lands one above the upper clamp and saturates to 0x7FFF
        load_coeffs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        send_word(CMD_CLEAR, 16'sh1234);
        send_word(CMD_FILTER, 16'sh8000);
        send_word(CMD_FILTER, 16'sh7FFF);
        i_in_valid <= 1'b0;
    endtask

    task automatic test_clear();
        wait_idle();
        load_coeffs(pack4(16'h4000, 16'h2000, 16'h1000, 16'h0800), {4{16'h0400}},
                    {4{16'hFC00}}, pack4(16'h0100, 16'h0200, 16'h0300, 16'h0400));
        send_word(CMD_FILTER, 16'sd1000);
        send_word(CMD_FILTER, 16'sd2000);
        send_word(CMD_CLEAR, 16'sh7FFF);
        send_word(CMD_CLEAR, 16'sh8000);
        send_word(CMD_FILTER, 16'sd3000);
        i_in_valid <= 1'b0;
    endtask

    task automatic test_unused_index();
        wait_idle();
        write_reg(REG_FIRST_UNUSED, '1);
        write_reg(REG_LAST_UNUSED, '1);
        i_cfg_valid <= 1'b0;
        send_word(CMD_FILTER, 16'sd12345);
        send_word(CMD_FILTER, -16'sd23456);
        i_in_valid <= 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_backpressure();
        wait_idle();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_len = 300;
        rx_hold_token++;
        repeat (60) send_word(CMD_FILTER, rand_sample());
        i_in_valid <= 1'b0;
    endtask

    task automatic test_random_phase(input int n_words, input t_coef_style style,
                                     input bit idle_on);
        logic cmd;
        wait_idle();
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_W'({$urandom, $urandom}));
        load_coeffs(rand_coeff_word(style), rand_coeff_word(style),
                    rand_coeff_word(style), rand_coeff_word(style));
        tx_idle_en = idle_on;
        rx_idle_en = idle_on;
        repeat (n_words) begin
            cmd = ($urandom_range(99) < 4) ? CMD_CLEAR : CMD_FILTER;
            send_word(cmd, rand_sample());
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        for (int t = 0; t < TAP_COUNT_DEF; t++) model_hist[t] = '0;
        for (int k = 0; k < 4; k++) model_coeff[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_unity_tap();
        test_saturation();
        test_clear();
        test_unused_index();
        test_backpressure();
        test_random_phase(300, COEF_FULL, 1'b1);
        test_random_phase(400, COEF_SMALL, 1'b0);
        test_random_phase(300, COEF_LANE_EXTREME, 1'b1);
        test_random_phase(350, COEF_SMALL, 1'b1);
        test_random_phase(250, COEF_FULL, 1'b1);

        wait_idle();
        if (error_count == 0) begin
            $display("fir16_q15_saturating_unit verification clean");
        end else begin
            $display("fir16_q15_saturating_unit verification failed");
        end
        $finish;
    end

endmodule
